>>> rtl/tpcc_pkg.sv
// Package: shared types and constants for the tracker pattern cell converter.
`default_nettype none
package tpcc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_TEMPO = 2'd1;

  // Wide enough for row numbers and row limits up to 256
  localparam int CMP_W = 9;

  // Special input bytes
  localparam logic [7:0] NB_NO_NOTE = 8'hFE;  // clears note and instrument
  localparam logic [7:0] NB_EMPTY   = 8'hFF;  // clears volume too
  localparam logic [7:0] EB_NONE    = 8'hFF;

  // Source effect codes
  localparam logic [3:0] FX_PORTA_UP   = 4'h0;
  localparam logic [3:0] FX_PORTA_DOWN = 4'h1;
  localparam logic [3:0] FX_TONE_PORTA = 4'h2;
  localparam logic [3:0] FX_VIBRATO    = 4'h4;
  localparam logic [3:0] FX_SPEED      = 4'h5;

  // Extended-effect subcommands (parameter high nibble)
  localparam logic [3:0] SUB_PORTA_UP   = 4'h1;
  localparam logic [3:0] SUB_PORTA_DOWN = 4'h2;
  localparam logic [3:0] SUB_TONE_PORTA = 4'h3;
  localparam logic [3:0] SUB_VIBRATO    = 4'h4;
  localparam logic [3:0] SUB_SPEED      = 4'hF;

  // Output codes
  localparam logic [6:0] EFF_NONE     = 7'h00;
  localparam logic [6:0] EFF_EXTENDED = 7'h70;
  localparam logic [3:0] VEFF_NONE    = 4'h0;
  localparam logic [3:0] VEFF_SET_VOL = 4'hC;
  localparam logic [6:0] NOTE_BIAS    = 7'd25;
  localparam logic [7:0] VOL_MAX      = 8'd255;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified cell waiting for the back end
  typedef struct packed {
    logic [7:0] note_byte;
    logic [7:0] info_byte;
    logic [7:0] effect_byte;
    logic [5:0] row;
    logic [3:0] channel;
    logic       insert;       // emit the channel-0 cell first
    logic       speed;        // channel-0 cell carries the speed command
    logic [3:0] tempo;
    logic       pattern_end;
  } cell_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage
`default_nettype wire

>>> rtl/tpcc_if.sv
// Interfaces: input cell, result cell and configuration write channels.
`default_nettype none
interface tpcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] note_byte;
  logic [7:0] info_byte;
  logic [7:0] effect_byte;
  modport source (output valid, output note_byte, output info_byte, output effect_byte,
                  input ready);
  modport sink (input valid, input note_byte, input info_byte, input effect_byte,
                output ready);
endinterface

interface tpcc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] channel;
  logic [5:0] row;
  logic [6:0] note;
  logic [6:0] instrument;
  logic [3:0] volume_effect;
  logic [7:0] volume;
  logic [6:0] effect;
  logic [7:0] effect_param;
  logic       last_in_run;
  logic       pattern_end;
  modport source (output valid, output channel, output row, output note, output instrument,
                  output volume_effect, output volume, output effect, output effect_param,
                  output last_in_run, output pattern_end, input ready);
  modport sink (input valid, input channel, input row, input note, input instrument,
                input volume_effect, input volume, input effect, input effect_param,
                input last_in_run, input pattern_end, output ready);
endinterface

interface tpcc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/tpcc_front.sv
// Front end: accepts cells, tracks row/channel position, classifies each cell.
`default_nettype none
module tpcc_front #(
  parameter int MAX_ROWS       = 64,
  parameter int INPUT_CHANNELS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  tpcc_in_if.sink                  in_ch,
  input  wire logic [6:0]          row_count,
  input  wire logic [5:0]          pattern_tempo,
  input  wire tpcc_pkg::queue_status_t q_status,
  output logic                     push,
  output tpcc_pkg::cell_entry_t    push_entry
);
  import tpcc_pkg::*;

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CH_W  = (INPUT_CHANNELS > 1) ? $clog2(INPUT_CHANNELS) : 1;

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic [CMP_W-1:0] row_ext, rows_lim;
  logic             accept, last_ch, in_range;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && !q_status.full;
  assign last_ch     = (ch_r == CH_W'(INPUT_CHANNELS - 1));

  // rows converted = min(row_count, MAX_ROWS)
  assign rows_lim = (CMP_W'(row_count) > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS)
                                                           : CMP_W'(row_count);
  assign row_ext  = CMP_W'(row_r);
  assign in_range = (row_ext < rows_lim);

  always_comb begin
    row_nxt = row_r;
    ch_nxt  = ch_r;
    if (accept) begin
      if (last_ch) begin
        ch_nxt  = '0;
        row_nxt = (row_r == ROW_W'(MAX_ROWS - 1)) ? '0 : ROW_W'(row_r + 1'b1);
      end else begin
        ch_nxt = CH_W'(ch_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      ch_r  <= '0;
    end else begin
      row_r <= row_nxt;
      ch_r  <= ch_nxt;
    end
  end

  // Cells beyond the converted rows are consumed and dropped here
  assign push = accept && in_range;

  always_comb begin
    push_entry.note_byte   = in_ch.note_byte;
    push_entry.info_byte   = in_ch.info_byte;
    push_entry.effect_byte = in_ch.effect_byte;
    push_entry.row         = 6'(row_ext);
    push_entry.channel     = 4'(6'(ch_r) + 6'd1);
    push_entry.insert      = (ch_r == '0);
    push_entry.speed       = (row_r == '0) && (pattern_tempo != '0);
    push_entry.tempo       = pattern_tempo[3:0];
    push_entry.pattern_end = last_ch && ((row_ext + 1'b1) == rows_lim);
  end

endmodule
`default_nettype wire

>>> rtl/tpcc_queue.sv
// Two-entry queue decoupling the front end from the back end.
`default_nettype none
module tpcc_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire tpcc_pkg::cell_entry_t push_entry,
  input  wire logic                 pop,
  output tpcc_pkg::cell_entry_t     head,
  output tpcc_pkg::queue_status_t   status
);
  import tpcc_pkg::*;

  cell_entry_t       mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push, do_pop;

  assign status.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_r + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/tpcc_back.sv
// Back end: decodes queued cells and drives the registered result channel.
`default_nettype none
module tpcc_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tpcc_pkg::cell_entry_t head,
  input  wire tpcc_pkg::queue_status_t q_status,
  output logic                      pop,
  tpcc_out_if.source                out_ch
);
  import tpcc_pkg::*;

  logic       out_valid_r;
  logic       ins_done_r;     // channel-0 cell of the head entry already sent
  logic       load, send_ins;
  logic [3:0] channel_r;
  logic [5:0] row_r;
  logic [6:0] note_r, ins_r, eff_r;
  logic [3:0] veff_r;
  logic [7:0] vol_r, par_r;
  logic       last_r, pend_r;

  // decoded cell
  logic [6:0] d_note, d_ins, d_eff;
  logic [3:0] d_veff, lo;
  logic [7:0] d_vol, d_par;

  assign lo = head.effect_byte[3:0];

  always_comb begin
    d_note = 7'(head.note_byte[7:2]) + NOTE_BIAS;
    d_ins  = 7'({head.note_byte[1:0], head.info_byte[7:4]}) + 7'd1;
    d_veff = VEFF_SET_VOL;
    d_vol  = (head.info_byte[3:0] == 4'hF) ? VOL_MAX
                                           : {4'(head.info_byte[3:0] + 4'd1), 4'h0};
    d_eff  = EFF_NONE;
    d_par  = '0;
    if (head.effect_byte != EB_NONE) begin
      case (head.effect_byte[7:4])
        FX_PORTA_UP:   begin d_eff = EFF_EXTENDED; d_par = {SUB_PORTA_UP, lo};   end
        FX_PORTA_DOWN: begin d_eff = EFF_EXTENDED; d_par = {SUB_PORTA_DOWN, lo}; end
        FX_TONE_PORTA: begin d_eff = EFF_EXTENDED; d_par = {SUB_TONE_PORTA, lo}; end
        FX_VIBRATO:    begin d_eff = EFF_EXTENDED; d_par = {SUB_VIBRATO, lo};    end
        FX_SPEED:      begin d_eff = EFF_EXTENDED; d_par = {SUB_SPEED, lo};      end
        default:       ;
      endcase
    end
    if (head.note_byte == NB_NO_NOTE) begin
      d_note = '0;
      d_ins  = '0;
    end else if (head.note_byte == NB_EMPTY) begin
      d_note = '0;
      d_ins  = '0;
      d_veff = VEFF_NONE;
      d_vol  = '0;
    end
  end

  assign load     = !q_status.empty && (!out_valid_r || out_ch.ready);
  assign send_ins = head.insert && !ins_done_r;
  assign pop      = load && !send_ins;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ins_done_r  <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        ins_done_r  <= send_ins;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_r <= head.row;
      if (send_ins) begin
        channel_r <= '0;
        note_r    <= '0;
        ins_r     <= '0;
        veff_r    <= VEFF_NONE;
        vol_r     <= '0;
        eff_r     <= head.speed ? EFF_EXTENDED : EFF_NONE;
        par_r     <= head.speed ? {SUB_SPEED, head.tempo} : 8'h00;
        last_r    <= 1'b0;
        pend_r    <= 1'b0;
      end else begin
        channel_r <= head.channel;
        note_r    <= d_note;
        ins_r     <= d_ins;
        veff_r    <= d_veff;
        vol_r     <= d_vol;
        eff_r     <= d_eff;
        par_r     <= d_par;
        last_r    <= 1'b1;
        pend_r    <= head.pattern_end;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.channel       = channel_r;
  assign out_ch.row           = row_r;
  assign out_ch.note          = note_r;
  assign out_ch.instrument    = ins_r;
  assign out_ch.volume_effect = veff_r;
  assign out_ch.volume        = vol_r;
  assign out_ch.effect        = eff_r;
  assign out_ch.effect_param  = par_r;
  assign out_ch.last_in_run   = last_r;
  assign out_ch.pattern_end   = pend_r;

endmodule
`default_nettype wire

>>> rtl/tracker_pattern_cell_converter_unit.sv
// Top level: tracker pattern cell converter (front end, queue, back end, config).
//
// Usage
//   in_ch  : one packed 3-byte pattern cell per transaction, row-major,
//            INPUT_CHANNELS cells per row, MAX_ROWS rows per pattern.
//   out_ch : decoded cells. The first cell of each row yields two
//            transactions (channel 0, then channel 1); others yield one.
//            last_in_run marks the final transaction of an input cell.
//            Cells in rows at or past row_count yield nothing.
//   cfg_ch : register writes (0 = row_count, 1 = pattern_tempo); always
//            ready, write only while the block is idle.
// Timing
//   An accepted cell sits in the queue after its accept edge; its first
//   result is registered from the queue head once the output register is
//   free. Throughput is one output transaction per cycle while the receiver
//   is ready, set by the single output register of the back end: one cell
//   per cycle on a row's later channels; a row's first cell takes two
//   transactions. The two-entry queue lets in_ch keep taking cells while
//   a result waits on a stalled receiver; in_ch.ready drops only if it is full.
// Reset: row 0 / channel 0, queue and output empty, row_count 64, tempo 0.
`default_nettype none
module tracker_pattern_cell_converter_unit #(
  parameter int MAX_ROWS       = 64,
  parameter int INPUT_CHANNELS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tpcc_in_if.sink    in_ch,
  tpcc_out_if.source out_ch,
  tpcc_cfg_if.sink   cfg_ch
);
  import tpcc_pkg::*;

  logic [6:0]    row_count_r;
  logic [5:0]    pattern_tempo_r;
  logic          push, pop;
  cell_entry_t   push_entry, head;
  queue_status_t q_status;

  // Configuration registers; writes to unknown indexes are ignored
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r     <= 7'd64;
      pattern_tempo_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ROW_COUNT:     row_count_r     <= cfg_ch.data[6:0];
        REG_PATTERN_TEMPO: pattern_tempo_r <= cfg_ch.data[5:0];
        default:           ;
      endcase
    end
  end

  // Front end: position tracking and classification
  tpcc_front #(
    .MAX_ROWS       (MAX_ROWS),
    .INPUT_CHANNELS (INPUT_CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .row_count     (row_count_r),
    .pattern_tempo (pattern_tempo_r),
    .q_status      (q_status),
    .push          (push),
    .push_entry    (push_entry)
  );

  // Decoupling queue
  tpcc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // Back end: decode and result register
  tpcc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // Front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("push into full queue");

  // Only the inserted channel-0 cell is not the last of its run
  a_insert_ch0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last_in_run) |-> (out_ch.channel == 4'd0))
    else $error("non-final result on a real channel");

  // Pattern end only on a cell's final result
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.pattern_end) |-> out_ch.last_in_run)
    else $error("pattern_end on non-final result");

  // Inserted cell is followed at once by channel 1 of the same row
  a_insert_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_in_run) |=>
      (out_ch.valid && out_ch.last_in_run && out_ch.channel == 4'd1 &&
       out_ch.row == $past(out_ch.row)))
    else $error("inserted cell not followed by channel 1");

endmodule
`default_nettype wire

>>> bench/tpcc_result_checker.sv
`timescale 1ns / 1ps
// Checker for the tracker pattern cell converter: decodes accepted cells and compares results.
module tpcc_result_checker
  import tpcc_pkg::*;
#(
  parameter int MAX_ROWS       = 64,
  parameter int INPUT_CHANNELS = 8
) (
  input  logic clk,
  input  logic rst_n,
  tpcc_in_if   in_ch,
  tpcc_out_if  out_ch,
  tpcc_cfg_if  cfg_ch,
  output int   error_count,
  output int   pending
);

  typedef struct packed {
    logic [3:0] channel;
    logic [5:0] row;
    logic [6:0] note;
    logic [6:0] instrument;
    logic [3:0] volume_effect;
    logic [7:0] volume;
    logic [6:0] effect;
    logic [7:0] effect_param;
    logic       last_in_run;
    logic       pattern_end;
  } decoded_cell_t;

  decoded_cell_t expected_cells[$];

  // Shadow of the block's position and registers
  int         cell_pos;
  logic [6:0] row_limit;
  logic [5:0] tempo_reg;
  int         mismatches = 0;
  int         queued = 0;

  assign error_count = mismatches;
  assign pending     = queued;

  // Expected results of one cell transaction, in order
  task automatic decode_cell(input logic [7:0] nb, input logic [7:0] ib, input logic [7:0] eb);
    int            row;
    int            chan;
    int            rows_eff;
    int            vol_sum;
    decoded_cell_t c;
    row      = cell_pos / INPUT_CHANNELS;
    chan     = cell_pos % INPUT_CHANNELS;
    rows_eff = (row_limit > MAX_ROWS) ? MAX_ROWS : int'(row_limit);
    cell_pos = (cell_pos + 1 >= MAX_ROWS * INPUT_CHANNELS) ? 0 : cell_pos + 1;
    if (row >= rows_eff) return;

    // row leader on channel 0, speed command only on row 0
    if (chan == 0) begin
      c = '0;
      c.row = row[5:0];
      if (row == 0 && tempo_reg != 6'd0) begin
        c.effect       = EFF_EXTENDED;
        c.effect_param = {SUB_SPEED, tempo_reg[3:0]};
      end
      expected_cells.push_back(c);
    end

    c = '0;
    c.channel       = 4'(chan + 1);
    c.row           = row[5:0];
    c.note          = 7'(nb[7:2]) + NOTE_BIAS;
    c.instrument    = 7'({nb[1:0], ib[7:4]}) + 7'd1;
    vol_sum         = (int'(ib[3:0]) + 1) * 16;
    c.volume        = (vol_sum > int'(VOL_MAX)) ? VOL_MAX : 8'(vol_sum);
    c.volume_effect = VEFF_SET_VOL;
    if (eb != EB_NONE) begin
      case (eb[7:4])
        FX_PORTA_UP: begin
          c.effect = EFF_EXTENDED; c.effect_param = {SUB_PORTA_UP, eb[3:0]};
        end
        FX_PORTA_DOWN: begin
          c.effect = EFF_EXTENDED; c.effect_param = {SUB_PORTA_DOWN, eb[3:0]};
        end
        FX_TONE_PORTA: begin
          c.effect = EFF_EXTENDED; c.effect_param = {SUB_TONE_PORTA, eb[3:0]};
        end
        FX_VIBRATO: begin
          c.effect = EFF_EXTENDED; c.effect_param = {SUB_VIBRATO, eb[3:0]};
        end
        FX_SPEED: begin
          c.effect = EFF_EXTENDED; c.effect_param = {SUB_SPEED, eb[3:0]};
        end
        default: ;
      endcase
    end
    if (nb == NB_NO_NOTE) begin
      c.note       = '0;
      c.instrument = '0;
    end else if (nb == NB_EMPTY) begin
      c.note          = '0;
      c.instrument    = '0;
      c.volume_effect = VEFF_NONE;
      c.volume        = '0;
    end
    c.last_in_run = 1'b1;
    c.pattern_end = (row + 1 == rows_eff) && (chan + 1 == INPUT_CHANNELS);
    expected_cells.push_back(c);
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    decoded_cell_t e;
    if (!rst_n) begin
      cell_pos  = 0;
      row_limit = 7'd64;
      tempo_reg = 6'd0;
      expected_cells.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_ROW_COUNT) row_limit = cfg_ch.data[6:0];
        else if (cfg_ch.index == REG_PATTERN_TEMPO) tempo_reg = cfg_ch.data[5:0];
      end
      if (in_ch.valid && in_ch.ready)
        decode_cell(in_ch.note_byte, in_ch.info_byte, in_ch.effect_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_cells.size() == 0) begin
          $error("result transaction with no cell waiting: channel %0d row %0d",
                 out_ch.channel, out_ch.row);
          mismatches++;
        end else begin
          e = expected_cells.pop_front();
          compare_field("channel", 8'(e.channel), 8'(out_ch.channel));
          compare_field("row", 8'(e.row), 8'(out_ch.row));
          compare_field("note", 8'(e.note), 8'(out_ch.note));
          compare_field("instrument", 8'(e.instrument), 8'(out_ch.instrument));
          compare_field("volume_effect", 8'(e.volume_effect), 8'(out_ch.volume_effect));
          compare_field("volume", e.volume, out_ch.volume);
          compare_field("effect", 8'(e.effect), 8'(out_ch.effect));
          compare_field("effect_param", e.effect_param, out_ch.effect_param);
          compare_field("last_in_run", 8'(e.last_in_run), 8'(out_ch.last_in_run));
          compare_field("pattern_end", 8'(e.pattern_end), 8'(out_ch.pattern_end));
        end
      end
    end
    queued = expected_cells.size();
  end

endmodule

>>> bench/tb_tracker_pattern_cell_converter_unit.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, cell and register stimulus, result sink and verdict.
module tb_tracker_pattern_cell_converter_unit;
  import tpcc_pkg::*;

  localparam int MAX_ROWS       = 64;
  localparam int INPUT_CHANNELS = 8;
  localparam int N_PHASES       = 6;
  localparam int N_DIRECTED     = 25;
  localparam int DRAIN_CYCLES   = 10;   // queue is 2 deep
  localparam int HOLD_START     = 400;  // sink hold-off lands inside the first pattern
  localparam int HOLD_CYCLES    = 300;

  logic clk;
  logic rst_n;
  int   error_count;
  int   pending;
  int   burst_left;

  tpcc_in_if  in_ch();
  tpcc_out_if out_ch();
  tpcc_cfg_if cfg_ch();

  tracker_pattern_cell_converter_unit #(
    .MAX_ROWS      (MAX_ROWS),
    .INPUT_CHANNELS(INPUT_CHANNELS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  tpcc_result_checker #(
    .MAX_ROWS      (MAX_ROWS),
    .INPUT_CHANNELS(INPUT_CHANNELS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .error_count(error_count),
    .pending    (pending)
  );

  // Register settings per phase, written raw. Cell counts are chosen so the
  // row-0 leader shows up under several tempos:
  //   0: reset values, one full pattern (directed cells first)
  //   1: one row only, tempo written as 0xFF -> 63 (nibble 15, bits above ignored)
  //   2: row count zero, every cell swallowed
  //   3: row count 65 clamps to 64, tempo 32 (low nibble zero) runs to pattern end
  //   4: 63 rows (last row swallowed), tempo 16 hits row 0 of the next pattern
  //   5: row count written as 0xFF -> 127, clamps to 64
  logic [7:0] phase_rows [N_PHASES] = '{8'd64, 8'd1, 8'd0, 8'd65, 8'd63, 8'hFF};
  logic [7:0] phase_tempo[N_PHASES] = '{8'd0, 8'hFF, 8'd17, 8'd32, 8'd16, 8'd1};
  int         phase_cells[N_PHASES] = '{512, 24, 40, 448, 520, 168};

  // Directed cells {note_byte, info_byte, effect_byte}: byte extremes, both
  // special note bytes, empty effect byte, every effect code 0..F, walking
  // bit patterns. Row leaders land on the 1st, 9th, 17th and 25th cell.
  logic [23:0] directed_cells[N_DIRECTED] = '{
    24'h000000, 24'hFFFFFF, 24'hFEFF0F, 24'hFDF010, 24'hFC0F1F,
    24'h03F020, 24'h800E2F, 24'h010730, 24'h02084A, 24'h400F5F,
    24'h7F105E, 24'hAA5560, 24'h55AA7F, 24'h33CC80, 24'hCC339F,
    24'hF0F7A5, 24'h0F3CB0, 24'hC3E1C7, 24'h3C1ED8, 24'hE700E9,
    24'h18FFF0, 24'hFB80FE, 24'hFE00FF, 24'hFF0F00, 24'h01F151
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // One register write; the port is always ready but the handshake is honored.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Offer one cell. Valid stays up across back-to-back transactions within a
  // burst; between bursts a random gap drops it (sometimes no gap at all).
  task automatic offer_cell(input logic [7:0] nb, input logic [7:0] ib, input logic [7:0] eb);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.note_byte   <= nb;
    in_ch.info_byte   <= ib;
    in_ch.effect_byte <= eb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Result sink: stretches of open, random and throttled ready, plus one long
  // hold-off early on so the internal queue fills and input backpressure kicks in.
  typedef enum {SINK_OPEN, SINK_RANDOM, SINK_THROTTLE, SINK_HOLD} sink_mode_t;

  initial begin : result_sink
    sink_mode_t mode;
    int         seg_len;
    int         cyc;
    logic       held;
    out_ch.ready = 1'b0;
    held = 1'b0;
    cyc  = 0;
    forever begin
      mode    = sink_mode_t'($urandom_range(0, 2));
      seg_len = $urandom_range(8, 64);
      if (!held && cyc >= HOLD_START) begin
        held    = 1'b1;
        mode    = SINK_HOLD;
        seg_len = HOLD_CYCLES;
      end
      repeat (seg_len) begin
        @(negedge clk);
        cyc++;
        case (mode)
          SINK_OPEN:     out_ch.ready <= 1'b1;
          SINK_RANDOM:   out_ch.ready <= 1'($urandom_range(0, 1));
          SINK_THROTTLE: out_ch.ready <= (cyc % 3 == 0);
          default:       out_ch.ready <= 1'b0;
        endcase
      end
    end
  end

  // Main stimulus
  initial begin : cell_source
    logic [7:0] nb;
    logic [7:0] ib;
    logic [7:0] eb;
    int         first_random;
    int         sel;

    in_ch.valid       = 1'b0;
    in_ch.note_byte   = 8'h00;
    in_ch.info_byte   = 8'h00;
    in_ch.effect_byte = 8'h00;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_ROW_COUNT;
    cfg_ch.data       = 8'h00;
    burst_left        = 0;

    // synchronous reset
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < N_PHASES; p++) begin
      // block is idle here: right after reset or after the previous drain
      write_reg(REG_ROW_COUNT, phase_rows[p]);
      write_reg(REG_PATTERN_TEMPO, phase_tempo[p]);

      first_random = 0;
      if (p == 0) begin
        for (int i = 0; i < N_DIRECTED; i++)
          offer_cell(directed_cells[i][23:16], directed_cells[i][15:8],
                     directed_cells[i][7:0]);
        first_random = N_DIRECTED;
      end

      for (int i = first_random; i < phase_cells[p]; i++) begin
        // note byte: mostly random, with the two special bytes often
        sel = $urandom_range(0, 9);
        if (sel == 0) nb = NB_NO_NOTE;
        else if (sel == 1) nb = NB_EMPTY;
        else nb = 8'($urandom_range(0, 255));
        ib = 8'($urandom_range(0, 255));
        // effect byte: empty, a mapped code, or anything
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          eb = EB_NONE;
        end else if (sel <= 6) begin
          case ($urandom_range(0, 4))
            0:       eb[7:4] = FX_PORTA_UP;
            1:       eb[7:4] = FX_PORTA_DOWN;
            2:       eb[7:4] = FX_TONE_PORTA;
            3:       eb[7:4] = FX_VIBRATO;
            default: eb[7:4] = FX_SPEED;
          endcase
          eb[3:0] = 4'($urandom_range(0, 15));
        end else begin
          eb = 8'($urandom_range(0, 255));
        end
        offer_cell(nb, ib, eb);
      end

      @(negedge clk);
      in_ch.valid <= 1'b0;
      burst_left = 0;

      // drain: every expected result in, then let swallowed cells clear the pipe
      while (pending != 0) @(negedge clk);
      repeat (DRAIN_CYCLES) @(negedge clk);
    end

    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
